@@ sv/itpdt_pkg.sv @@
// ----------------------------------------------------------------------------
// itpdt_pkg: shared types and constants for the padded decimal text block
// Character codes, digit cell control word and sequencer states.
// ----------------------------------------------------------------------------
package itpdt_pkg;

  localparam int NumBits         = 32;
  localparam int NumDigits       = 10;
  localparam int DigitIdxW       = $clog2(NumDigits);
  localparam int CntW            = $clog2(NumBits);
  localparam int WidthInW        = 6;
  localparam int TextLenW        = 4;
  localparam int MaxWidthDefault = 32;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharNul   = 8'h00;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StPrep = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

@@ sv/integer_to_padded_decimal_text.sv @@
// ----------------------------------------------------------------------------
// integer_to_padded_decimal_text: signed integer to right-aligned ascii text
// One input word (value, field width) gives field width characters and a
// zero terminator marked last.
// ----------------------------------------------------------------------------
// An item is accepted, W being the field width saturated to MAX_WIDTH,
// and its magnitude is shifted bit by bit through the row of ten bcd digit
// cells. The text is then sized, and W characters and the terminator are
// sent through the single output register, held while the output stalls.
// The next item is accepted as soon as the terminator sits in the output register.
module integer_to_padded_decimal_text
  import itpdt_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // num_value[31:0], field_width[37:32], zero fill
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_char[7:0]
  output logic        m_axis_tlast_o   // last_char
);

  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int CW  = (WCW > WidthInW) ? WCW : WidthInW;

  state_e state_q, state_d;

  logic [NumBits-1:0]  mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [WCW-1:0]      width_q, width_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [WCW-1:0]      idx_q, idx_d;
  logic [WCW-1:0]      blanks_q, blanks_d;
  logic [TextLenW-1:0] len_q, len_d;
  logic [TextLenW-1:0] ndig_q, ndig_d;
  logic                ov_q, ov_d;
  logic [7:0]          och_q, och_d;
  logic                olast_q, olast_d;

  cell_ctrl_t          cell_ctrl;
  logic [NumDigits:0]  chain;
  logic [3:0]          digits [NumDigits];

  logic [NumBits-1:0]  in_val;
  logic [WidthInW-1:0] in_width;
  logic                in_neg;
  logic [TextLenW-1:0] ndig_c;
  logic [WCW-1:0]      len_ext;
  logic [WCW-1:0]      k;
  logic [3:0]          pos;
  logic [DigitIdxW-1:0] dsel;
  logic [3:0]          dval;
  logic [7:0]          ch;
  logic                out_free;

  // digit cell row, least significant digit first
  assign chain[0] = mag_q[NumBits-1];
  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    itpdt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .bit_i   (chain[g]),
      .bit_o   (chain[g+1]),
      .digit_o (digits[g])
    );
  end

  assign in_val   = s_axis_tdata_i[NumBits-1:0];
  assign in_width = s_axis_tdata_i[NumBits+WidthInW-1:NumBits];
  assign in_neg   = in_val[NumBits-1];

  // count of significant digits, at least one
  always_comb begin
    ndig_c = TextLenW'(1);
    for (int i = 1; i < NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        ndig_c = TextLenW'(i + 1);
      end
    end
  end

  // character at the current position
  always_comb begin
    k    = idx_q - blanks_q;
    pos  = ndig_q - 4'd1 - (4'(k) - {3'b000, neg_q});
    dsel = DigitIdxW'(pos);
    dval = (32'(dsel) < NumDigits) ? digits[dsel] : 4'd0;
    if (idx_q < blanks_q) begin
      ch = CharSpace;
    end else if (neg_q && (k == '0)) begin
      ch = CharMinus;
    end else begin
      ch = CharZero | {4'd0, dval};
    end
  end

  assign len_ext  = WCW'(len_q);
  assign out_free = !ov_q || m_axis_tready_i;

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    width_d   = width_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    blanks_d  = blanks_q;
    len_d     = len_q;
    ndig_d    = ndig_q;
    ov_d      = ov_q;
    och_d     = och_q;
    olast_d   = olast_q;
    cell_ctrl = '0;

    if (m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          mag_d = in_neg ? (~in_val + NumBits'(1)) : in_val;
          neg_d = in_neg;
          width_d = (CW'(in_width) > CW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH)
                                                     : WCW'(in_width);
          cnt_d           = '0;
          cell_ctrl.clear = 1'b1;
          state_d         = StConv;
        end
      end
      StConv: begin
        cell_ctrl.shift = 1'b1;
        mag_d           = {mag_q[NumBits-2:0], 1'b0};
        cnt_d           = cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumBits - 1)) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        ndig_d  = ndig_c;
        len_d   = ndig_c + {3'b000, neg_q};
        idx_d   = '0;
        state_d = StEmit;
      end
      StEmit: begin
        blanks_d = (width_q > len_ext) ? width_q - len_ext : '0;
        if (out_free) begin
          ov_d = 1'b1;
          if (idx_q == width_q) begin
            och_d   = CharNul;
            olast_d = 1'b1;
            state_d = StIdle;
          end else begin
            och_d   = ch;
            olast_d = 1'b0;
            idx_d   = idx_q + WCW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (state_q == StPrep) begin
      blanks_d = (width_q > WCW'(ndig_c + {3'b000, neg_q}))
               ? width_q - WCW'(ndig_c + {3'b000, neg_q}) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    neg_q    <= neg_d;
    width_q  <= width_d;
    blanks_q <= blanks_d;
    len_q    <= len_d;
    ndig_q   <= ndig_d;
    och_q    <= och_d;
    olast_q  <= olast_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = och_q;
  assign m_axis_tlast_o  = olast_q;

  // assertions
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (idx_q <= width_q))
    else $error("character index beyond field width");

  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StConv) && (cnt_q == CntW'(NumBits - 1))) |=> (state_q == StPrep))
    else $error("conversion did not end after full shift");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> ((state_q == StConv) && (cnt_q == '0)))
    else $error("accepted word did not start conversion");

  a_text_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> ((ndig_q >= 4'd1) && (ndig_q <= 4'(NumDigits))
                             && (len_q == ndig_q + {3'b000, neg_q})))
    else $error("text length out of range");

  a_term_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o == CharNul))
    else $error("terminator word carries a character");

endmodule

@@ sv/itpdt_cell.sv @@
// ----------------------------------------------------------------------------
// itpdt_cell: one bcd digit of the shift-and-add-three chain
// Adds three when the digit is five or more, then shifts in the bit from the
// lower neighbour and hands its top bit to the upper neighbour.
// ----------------------------------------------------------------------------
module itpdt_cell
  import itpdt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       bit_i,
  output logic       bit_o,
  output logic [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ verif/padded_text_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_text_checker: scoreboard for the padded decimal text block
// Watches the input and output streams, works out the characters that each
// accepted word should give and compares every output word with the oldest
// character still expected. Hands the failure count and the number of
// characters still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module padded_text_checker
  import itpdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,   // num_value[31:0], field_width[37:32], zero fill
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // out_char[7:0]
  input  logic        m_axis_tlast_i,   // last_char
  output int          fail_count_o,
  output int          chars_pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_chars_q[$];
  int         fail_count;

  // right-aligned decimal text of one word, then the terminator
  function automatic void queue_padded_text(input logic [31:0] raw, input logic [5:0] width_in);
    logic [7:0]  digits_rev [0:9];
    logic [7:0]  text_buf [0:10];
    logic [31:0] mag;
    logic [7:0]  ch;
    int          ndig;
    int          tlen;
    int          field_w;
    int          blanks;
    int          k;
    ndig = 0;
    tlen = 0;
    mag  = raw[31] ? (~raw + 32'd1) : raw;
    do begin
      digits_rev[ndig] = CharZero + 8'(mag % 32'd10);
      ndig++;
      mag = mag / 32'd10;
    end while (mag != 32'd0 && ndig < NumDigits);
    if (raw[31]) begin
      text_buf[tlen] = CharMinus;
      tlen++;
    end
    while (ndig > 0) begin
      ndig--;
      text_buf[tlen] = digits_rev[ndig];
      tlen++;
    end
    field_w = int'(width_in);
    if (field_w > MaxWidthDefault) begin
      field_w = MaxWidthDefault;
    end
    blanks = (field_w > tlen) ? field_w - tlen : 0;
    for (int i = 0; i < field_w; i++) begin
      k = i - blanks;
      if (i < blanks || k >= tlen) begin
        ch = CharSpace;
      end else begin
        ch = text_buf[k];
      end
      expected_chars_q.push_back('{ch: ch, last: 1'b0});
    end
    expected_chars_q.push_back('{ch: CharNul, last: 1'b1});
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        queue_padded_text(s_axis_tdata_i[31:0], s_axis_tdata_i[37:32]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected output word: out_char %h last_char %b",
                 m_axis_tdata_i, m_axis_tlast_i);
          fail_count++;
        end else begin
          want = expected_chars_q.pop_front();
          if (m_axis_tdata_i !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, m_axis_tdata_i);
            fail_count++;
          end
          if (m_axis_tlast_i !== want.last) begin
            $error("last_char: expected %b, got %b", want.last, m_axis_tlast_i);
            fail_count++;
          end
        end
      end
    end
    fail_count_o    <= fail_count;
    chars_pending_o <= expected_chars_q.size();
  end

endmodule

@@ verif/integer_to_padded_decimal_text_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_padded_decimal_text_tb: testbench for the padded decimal text block
// Sends directed words (value and width extremes, the most negative value,
// zero width, saturated and truncating widths) and then random words, with
// random gaps and stalls on both streams, a long output hold-off and a full
// drain pause. A separate checker predicts and compares the characters.
// ----------------------------------------------------------------------------
module integer_to_padded_decimal_text_tb;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count;
  int          chars_pending;
  bit          random_phase;

  integer_to_padded_decimal_text i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  padded_text_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(200000 * 20);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_word(input logic [31:0] value, input logic [5:0] width_in,
                           input bit no_gaps);
    while (!no_gaps && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, width_in, value};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = -($urandom >> $urandom_range(0, 31));
      default: v = $urandom_range(0, 1) ? $urandom_range(0, 20) : -$urandom_range(0, 20);
    endcase
    return v;
  endfunction

  function automatic logic [5:0] pick_width();
    logic [5:0] w;
    case ($urandom_range(0, 9))
      0: w = 6'($urandom_range(33, 63));
      1, 2: w = 6'($urandom_range(0, 32));
      default: w = 6'($urandom_range(0, 16));
    endcase
    return w;
  endfunction

  // output side: random stalls, one long hold-off and one stretch with none
  initial begin
    int cyc;
    cyc = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (random_phase) begin
        cyc++;
      end
      if (cyc >= 200 && cyc < 600) begin
        m_axis_tready <= 1'b0;
      end else if (cyc >= 1000 && cyc < 2500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  initial begin
    logic [31:0] dir_values [0:21];
    logic [5:0]  dir_widths [0:21];
    dir_values = '{32'd0, 32'd0, 32'd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'd9, 32'd10, -32'sd10, 32'd999999999,
                   32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, -32'sd12345,
                   32'd42, -32'sd7, 32'h7FFF_FFFF, 32'd5, 32'hFFFF_FFFF, 32'd123};
    dir_widths = '{6'd1, 6'd0, 6'd32, 6'd2, 6'd10, 6'd11, 6'd5, 6'd32, 6'd1, 6'd2, 6'd3,
                   6'd9, 6'd12, 6'd33, 6'd63, 6'd4, 6'd40, 6'd1, 6'd31, 6'd0, 6'd21, 6'd3};
    random_phase  <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rst_n         <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 22; i++) begin
      send_word(dir_values[i], dir_widths[i], 1'b0);
    end
    wait_drained();
    random_phase <= 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_word(pick_value(), pick_width(), i >= 40 && i < 70);
    end
    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
